@@ design/assert_macros.svh @@
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked while out of reset
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked on every edge, reset included
`define ASSERT_EVERY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RUN(label, clk, rst, prop)
`define ASSERT_EVERY(label, clk, prop)

`endif

`endif

@@ design/hvtc_pkg.sv @@
// ----------------------------------------------------------------------------
// hvtc_pkg
// Types, character codes and the void element name table for the tag closer.
// ----------------------------------------------------------------------------
package hvtc_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_AFTER_LT,
    MODE_NAME,
    MODE_ATTR
  } scan_mode_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam int VOID_COUNT  = 14;
  localparam int VOID_NAME_W = 6;

  localparam logic [7:0] VOID_NAMES [VOID_COUNT][VOID_NAME_W] = '{
    '{"a", "r", "e", "a", 8'h00, 8'h00},
    '{"b", "a", "s", "e", 8'h00, 8'h00},
    '{"b", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "l", 8'h00, 8'h00, 8'h00},
    '{"e", "m", "b", "e", "d", 8'h00},
    '{"h", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "m", "g", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "p", "u", "t", 8'h00},
    '{"l", "i", "n", "k", 8'h00, 8'h00},
    '{"m", "e", "t", "a", 8'h00, 8'h00},
    '{"p", "a", "r", "a", "m", 8'h00},
    '{"s", "o", "u", "r", "c", "e"},
    '{"t", "r", "a", "c", "k", 8'h00},
    '{"w", "b", "r", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] VOID_LEN [VOID_COUNT] = '{
    3'd4, 3'd4, 3'd2, 3'd3, 3'd5, 3'd2, 3'd3,
    3'd5, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd3
  };

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCOUNT_W = 3;

  // one scanned byte handed to the output queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       insert;
  } out_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       doc_last;
  } q_entry_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= CH_UC_A && b <= CH_UC_Z) ? b + CASE_GAP : b;
  endfunction

endpackage

@@ design/hvtc_scanner.sv @@
// ----------------------------------------------------------------------------
// hvtc_scanner
// Tag scanner: tracks the tag being read and flags a '>' that needs a slash.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hvtc_scanner #(
  parameter int NAME_MAX = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output hvtc_pkg::out_req_t  req
);

  localparam int LEN_W = $clog2(NAME_MAX + 1);
  localparam int IDX_W = $clog2(NAME_MAX);

  hvtc_pkg::scan_mode_t mode, mode_next;
  logic [7:0]       name_store [NAME_MAX];
  logic [LEN_W-1:0] name_length, name_length_next;
  logic             name_overlong, name_overlong_next;
  logic             tag_is_void, tag_is_void_next;
  logic             prev_was_slash, prev_was_slash_next;
  logic             store_we;
  logic             match, hit, name_void, insert;
  logic [7:0]       folded;

  assign folded = hvtc_pkg::fold(in_byte);

  // compare the stored name against every void element name
  always_comb begin
    match = 1'b0;
    hit   = 1'b0;
    for (int k = 0; k < hvtc_pkg::VOID_COUNT; k++) begin
      hit = (name_length == LEN_W'(hvtc_pkg::VOID_LEN[k]));
      for (int j = 0; j < hvtc_pkg::VOID_NAME_W; j++) begin
        if (j < hvtc_pkg::VOID_LEN[k] && name_store[j] != hvtc_pkg::VOID_NAMES[k][j]) begin
          hit = 1'b0;
        end
      end
      match = match | hit;
    end
  end

  assign name_void = !name_overlong && (name_length != '0) && match;

  always_comb begin
    mode_next           = mode;
    name_length_next    = name_length;
    name_overlong_next  = name_overlong;
    tag_is_void_next    = tag_is_void;
    prev_was_slash_next = prev_was_slash;
    store_we            = 1'b0;
    insert              = 1'b0;
    unique case (mode)
      hvtc_pkg::MODE_TEXT: begin
        if (in_byte == hvtc_pkg::CH_LT) begin
          name_length_next    = '0;
          name_overlong_next  = 1'b0;
          tag_is_void_next    = 1'b0;
          prev_was_slash_next = 1'b0;
          mode_next           = hvtc_pkg::MODE_AFTER_LT;
        end
      end
      hvtc_pkg::MODE_AFTER_LT: begin
        if (in_byte == hvtc_pkg::CH_SLASH || in_byte == hvtc_pkg::CH_BANG ||
            in_byte == hvtc_pkg::CH_QUEST || in_byte == hvtc_pkg::CH_GT) begin
          mode_next = hvtc_pkg::MODE_TEXT;
        end else if (hvtc_pkg::is_space(in_byte)) begin
          tag_is_void_next    = 1'b0;
          prev_was_slash_next = 1'b0;
          mode_next           = hvtc_pkg::MODE_ATTR;
        end else begin
          // name_length is zero here, so the write lands in the first slot
          store_we            = 1'b1;
          name_length_next    = LEN_W'(1);
          prev_was_slash_next = 1'b0;
          mode_next           = hvtc_pkg::MODE_NAME;
        end
      end
      hvtc_pkg::MODE_NAME: begin
        if (in_byte == hvtc_pkg::CH_GT) begin
          insert    = name_void && !prev_was_slash;
          mode_next = hvtc_pkg::MODE_TEXT;
        end else if (in_byte == hvtc_pkg::CH_SLASH || hvtc_pkg::is_space(in_byte)) begin
          tag_is_void_next    = name_void;
          prev_was_slash_next = (in_byte == hvtc_pkg::CH_SLASH);
          mode_next           = hvtc_pkg::MODE_ATTR;
        end else begin
          if (name_length < LEN_W'(NAME_MAX)) begin
            store_we         = 1'b1;
            name_length_next = name_length + LEN_W'(1);
          end else begin
            name_overlong_next = 1'b1;
          end
          prev_was_slash_next = 1'b0;
        end
      end
      hvtc_pkg::MODE_ATTR: begin
        if (in_byte == hvtc_pkg::CH_GT) begin
          insert    = tag_is_void && !prev_was_slash;
          mode_next = hvtc_pkg::MODE_TEXT;
        end else begin
          prev_was_slash_next = (in_byte == hvtc_pkg::CH_SLASH);
        end
      end
      default: mode_next = hvtc_pkg::MODE_TEXT;
    endcase
    // end of document drops any open tag
    if (in_last) begin
      mode_next           = hvtc_pkg::MODE_TEXT;
      name_length_next    = '0;
      name_overlong_next  = 1'b0;
      tag_is_void_next    = 1'b0;
      prev_was_slash_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= hvtc_pkg::MODE_TEXT;
      name_length    <= '0;
      name_overlong  <= 1'b0;
      tag_is_void    <= 1'b0;
      prev_was_slash <= 1'b0;
    end else if (fire) begin
      mode           <= mode_next;
      name_length    <= name_length_next;
      name_overlong  <= name_overlong_next;
      tag_is_void    <= tag_is_void_next;
      prev_was_slash <= prev_was_slash_next;
    end
  end

  // name bytes are only read below name_length, so they need no reset
  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      name_store[name_length[IDX_W-1:0]] <= folded;
    end
  end

  assign req.data   = in_byte;
  assign req.last   = in_last;
  assign req.insert = insert;

  `ASSERT_RUN(a_doc_end_text, clk, rst,
    fire && in_last |=> mode == hvtc_pkg::MODE_TEXT && name_length == '0)
  `ASSERT_RUN(a_len_bound, clk, rst, name_length <= LEN_W'(NAME_MAX))
  `ASSERT_RUN(a_insert_on_gt, clk, rst,
    req.insert |-> in_byte == hvtc_pkg::CH_GT && mode != hvtc_pkg::MODE_TEXT)

endmodule

@@ design/hvtc_out_queue.sv @@
// ----------------------------------------------------------------------------
// hvtc_out_queue
// Four-entry output queue: takes one or two result bytes per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hvtc_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hvtc_pkg::out_req_t req,
  output logic               space,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // out_byte
  output logic               m_tuser,   // run_last
  output logic               m_tlast    // doc_last
);

  hvtc_pkg::q_entry_t mem [hvtc_pkg::QDEPTH];
  logic [hvtc_pkg::QPTR_W-1:0]   wp, rp;
  logic [hvtc_pkg::QCOUNT_W-1:0] count, count_next;
  logic                          pop;
  hvtc_pkg::q_entry_t            slash_entry, byte_entry, head;

  assign space = (count <= hvtc_pkg::QCOUNT_W'(hvtc_pkg::QDEPTH - 2));
  assign pop   = m_tvalid && m_tready;

  assign slash_entry = '{data: hvtc_pkg::CH_SLASH, run_last: 1'b0, doc_last: 1'b0};
  assign byte_entry  = '{data: req.data, run_last: 1'b1, doc_last: req.last};

  always_comb begin
    count_next = count - hvtc_pkg::QCOUNT_W'(pop);
    if (push) begin
      count_next = count_next + (req.insert ? hvtc_pkg::QCOUNT_W'(2) : hvtc_pkg::QCOUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rp <= rp + hvtc_pkg::QPTR_W'(1);
      end
      if (push) begin
        wp <= wp + (req.insert ? hvtc_pkg::QPTR_W'(2) : hvtc_pkg::QPTR_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (req.insert) begin
        mem[wp]                        <= slash_entry;
        mem[wp + hvtc_pkg::QPTR_W'(1)] <= byte_entry;
      end else begin
        mem[wp] <= byte_entry;
      end
    end
  end

  assign head     = mem[rp];
  assign m_tvalid = (count != '0);
  assign m_tdata  = head.data;
  assign m_tuser  = head.run_last;
  assign m_tlast  = head.doc_last;

  `ASSERT_RUN(a_count_bound, clk, rst, count <= hvtc_pkg::QCOUNT_W'(hvtc_pkg::QDEPTH))
  // an inserted slash is always followed by its '>' already queued
  `ASSERT_RUN(a_slash_pair, clk, rst, m_tvalid && !m_tuser |-> count >= hvtc_pkg::QCOUNT_W'(2))
  `ASSERT_EVERY(a_reset_empty, clk, rst |=> count == '0 && wp == rp)

endmodule

@@ design/html_void_tag_closer.sv @@
// ----------------------------------------------------------------------------
// html_void_tag_closer
// Copies an HTML byte stream and closes void element tags with a slash.
// ----------------------------------------------------------------------------
// The slave channel takes one text byte per request, tlast on the final byte
// of a document. The master channel gives the repaired bytes: tdata the byte,
// tuser high on the last output of an input byte, tlast high on the final
// output of the document.
// Each input byte is scanned in the cycle it is taken; its outputs go into a
// four-entry queue and leave from its head. A '>' that closes a void
// element tag yields two outputs, the slash and then the '>'.
// Throughput is one input byte per cycle while the receiver keeps up; each
// inserted slash adds a byte to send through the single output port
// of the queue. s_tready stays high while two queue entries are free, so a
// stalled receiver fills the queue and then holds the input back; nothing is
// lost or dropped.
// Reset empties the queue and returns the scanner to plain text; the end of a
// document does the same for the scanner, dropping any open tag.
// ----------------------------------------------------------------------------
module html_void_tag_closer #(
  parameter int NAME_MAX = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast    // doc_last
);

  logic               fire;
  logic               space;
  hvtc_pkg::out_req_t req;

  assign s_tready = space;
  assign fire     = s_tvalid && s_tready;

  hvtc_scanner #(
    .NAME_MAX (NAME_MAX)
  ) u_scanner (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .req     (req)
  );

  hvtc_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .req      (req),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
